@@ design/vru_pkg.sv @@
// ---------------------------------------------------------------------------
// vru_pkg
// Widths, constants and sideband types shared by the refraction pipeline.
// ---------------------------------------------------------------------------
package vru_pkg;

   localparam int FRAC_BITS = 14;
   localparam int COMP_W    = 16;
   localparam int IDX_W     = 16;
   localparam int VEC_W     = COMP_W + 1;
   localparam int CROSS_W   = 19;
   localparam int CSQ_W     = 35;
   localparam int CC_W      = 22;
   localparam int UVEC_W    = 21;
   localparam int R2_W      = 2 * IDX_W - FRAC_BITS;
   localparam int PROD_W    = R2_W + CC_W;
   localparam int ROOT1_W   = FRAC_BITS + 1;
   localparam int RU_W      = UVEC_W + IDX_W + 1;
   localparam int NS_W      = VEC_W + ROOT1_W + 1;
   localparam int MAG_W     = RU_W;
   localparam int NORM_W    = 64;
   localparam int NORM_STEPS = 6;
   localparam int NMAN_W    = 30;
   localparam int SUMSQ_W   = 2 * NMAN_W + 2;
   localparam int ROOT2_W   = SUMSQ_W / 2;
   localparam int NUM_W     = NMAN_W + FRAC_BITS + 1;
   localparam int QUO_W     = 16;

   localparam logic [PROD_W-1:0] ONE_SQ = PROD_W'(1) << (2 * FRAC_BITS);

   typedef struct packed {
      logic                          sat;
      logic [2:0][VEC_W-1:0]         dir;
      logic [2:0][VEC_W-1:0]         nrm;
   } div_side_type;

   typedef struct packed {
      logic                          tir;
      logic [IDX_W-1:0]              ratio;
      logic [2:0][UVEC_W-1:0]        uvec;
      logic [2:0][VEC_W-1:0]         nrm;
   } root_side_type;

   typedef struct packed {
      logic                          tir;
      logic                          deg;
      logic [2:0]                    neg;
      logic [2:0][NMAN_W-1:0]        mag;
   } len_side_type;

   typedef struct packed {
      logic                          tir;
      logic                          deg;
      logic                          neg;
   } lane_side_type;

endpackage

@@ design/vru_div.sv @@
// ---------------------------------------------------------------------------
// vru_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ---------------------------------------------------------------------------
module vru_div #(
   parameter int DW = 16,
   parameter int QW = 16,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          valid_i,
   input  logic [DW-1:0] num_hi,
   input  logic [QW-1:0] num_lo,
   input  logic [DW-1:0] den,
   input  logic [SW-1:0] side_i,
   output logic          valid_o,
   output logic [QW-1:0] quo,
   output logic [SW-1:0] side_o
);

   logic [QW-1:0]  valid_ff;
   logic [DW-1:0]  rem_ff  [QW];
   logic [DW-1:0]  rem_in  [QW];
   logic [QW-1:0]  lo_ff   [QW];
   logic [QW-1:0]  lo_in   [QW];
   logic [QW-1:0]  q_ff    [QW];
   logic [QW-1:0]  q_in    [QW];
   logic [DW-1:0]  den_ff  [QW];
   logic [SW-1:0]  side_ff [QW];

   always_comb begin
      logic [DW-1:0] rp;
      logic [QW-1:0] lp;
      logic [QW-1:0] qp;
      logic [DW-1:0] dp;
      logic [DW:0]   t;
      for (int i = 0; i < QW; i++) begin
         if (i == 0) begin
            rp = num_hi;
            lp = num_lo;
            qp = '0;
            dp = den;
         end else begin
            rp = rem_ff[i-1];
            lp = lo_ff[i-1];
            qp = q_ff[i-1];
            dp = den_ff[i-1];
         end
         t = {rp, lp[QW-1]};
         if (t >= {1'b0, dp}) begin
            rem_in[i] = DW'(t - {1'b0, dp});
            q_in[i]   = QW'({qp, 1'b1});
         end else begin
            rem_in[i] = DW'(t);
            q_in[i]   = QW'({qp, 1'b0});
         end
         lo_in[i] = lp << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= QW'({valid_ff, valid_i});
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < QW; i++) begin
            rem_ff[i] <= rem_in[i];
            lo_ff[i]  <= lo_in[i];
            q_ff[i]   <= q_in[i];
            if (i == 0) begin
               den_ff[i]  <= den;
               side_ff[i] <= side_i;
            end else begin
               den_ff[i]  <= den_ff[i-1];
               side_ff[i] <= side_ff[i-1];
            end
         end
      end
   end

   assign valid_o = valid_ff[QW-1];
   assign quo     = q_ff[QW-1];
   assign side_o  = side_ff[QW-1];

endmodule

@@ design/vru_sqrt.sv @@
// ---------------------------------------------------------------------------
// vru_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ---------------------------------------------------------------------------
module vru_sqrt #(
   parameter int RW = 15,
   parameter int SW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            enable,
   input  logic            valid_i,
   input  logic [2*RW-1:0] rad,
   input  logic [SW-1:0]   side_i,
   output logic            valid_o,
   output logic [RW-1:0]   root,
   output logic [SW-1:0]   side_o
);

   logic [RW-1:0]   valid_ff;
   logic [RW+1:0]   rem_ff  [RW];
   logic [RW+1:0]   rem_in  [RW];
   logic [RW-1:0]   root_ff [RW];
   logic [RW-1:0]   root_in [RW];
   logic [2*RW-1:0] x_ff    [RW];
   logic [2*RW-1:0] x_in    [RW];
   logic [SW-1:0]   side_ff [RW];

   always_comb begin
      logic [RW+1:0]   rp;
      logic [RW-1:0]   op;
      logic [2*RW-1:0] xp;
      logic [RW+3:0]   t;
      logic [RW+3:0]   trial;
      for (int i = 0; i < RW; i++) begin
         if (i == 0) begin
            rp = '0;
            op = '0;
            xp = rad;
         end else begin
            rp = rem_ff[i-1];
            op = root_ff[i-1];
            xp = x_ff[i-1];
         end
         t     = {rp, xp[2*RW-1 -: 2]};
         trial = (RW+4)'({op, 2'b01});
         if (t >= trial) begin
            rem_in[i]  = (RW+2)'(t - trial);
            root_in[i] = RW'({op, 1'b1});
         end else begin
            rem_in[i]  = (RW+2)'(t);
            root_in[i] = RW'({op, 1'b0});
         end
         x_in[i] = xp << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= RW'({valid_ff, valid_i});
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < RW; i++) begin
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            x_ff[i]    <= x_in[i];
            if (i == 0) begin
               side_ff[i] <= side_i;
            end else begin
               side_ff[i] <= side_ff[i-1];
            end
         end
      end
   end

   assign valid_o = valid_ff[RW-1];
   assign root    = root_ff[RW-1];
   assign side_o  = side_ff[RW-1];

endmodule

@@ design/vector_refraction_unit.sv @@
// ---------------------------------------------------------------------------
// vector_refraction_unit
// Vector Snell refraction of one ray at one surface, Q2.14, fully pipelined.
// ---------------------------------------------------------------------------
// Takes one ray per clock while rsp_tready does not hold the pipeline and returns
// one result per ray, in order. The pipeline is a chain of the index-ratio divider,
// radicand square root, normalizing shifter, length square root and output
// dividers, plus 12 arithmetic stages. The whole pipeline holds while a result
// waits on rsp_tready; req_tready falls only then.
module vector_refraction_unit
   import vru_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // dir_x, dir_y, dir_z, normal_x, normal_y, normal_z, index_in, index_out
   input  logic [127:0] req_tdata,
   // flip_normal
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x, out_y, out_z
   output logic [47:0]  rsp_tdata,
   // total_reflection
   output logic [0:0]   rsp_tuser
);

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // input stage
   logic                  a_valid_ff;
   logic [2:0][VEC_W-1:0] a_dir_ff, a_dir_in;
   logic [2:0][VEC_W-1:0] a_nrm_ff, a_nrm_in;
   logic [IDX_W-1:0]      a_n1_ff;
   logic [IDX_W-1:0]      a_n2_ff, a_n2_in;

   always_comb begin
      logic [COMP_W-1:0] nr;
      for (int k = 0; k < 3; k++) begin
         a_dir_in[k] = VEC_W'($signed(req_tdata[COMP_W*k +: COMP_W]));
         nr          = req_tdata[COMP_W*(k+3) +: COMP_W];
         if (req_tuser[0]) begin
            a_nrm_in[k] = -VEC_W'($signed(nr));
         end else begin
            a_nrm_in[k] = VEC_W'($signed(nr));
         end
      end
      a_n2_in = req_tdata[127:112];
      if (a_n2_in == '0) begin
         a_n2_in = IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_dir_ff <= a_dir_in;
         a_nrm_ff <= a_nrm_in;
         a_n1_ff  <= req_tdata[111:96];
         a_n2_ff  <= a_n2_in;
      end
   end

   // index ratio
   div_side_type     d1_side_in, d1_side;
   logic             d1_valid;
   logic [QUO_W-1:0] d1_quo;

   always_comb begin
      d1_side_in.sat = {2'b00, a_n1_ff} >= {a_n2_ff, 2'b00};
      d1_side_in.dir = a_dir_ff;
      d1_side_in.nrm = a_nrm_ff;
   end

   vru_div #(.DW(IDX_W), .QW(QUO_W), .SW($bits(div_side_type))) u_ratio_div (
      .clock   (clock),
      .reset   (reset),
      .enable  (adv),
      .valid_i (a_valid_ff),
      .num_hi  (IDX_W'(a_n1_ff[IDX_W-1:2])),
      .num_lo  ({a_n1_ff[1:0], {FRAC_BITS{1'b0}}}),
      .den     (a_n2_ff),
      .side_i  (d1_side_in),
      .valid_o (d1_valid),
      .quo     (d1_quo),
      .side_o  (d1_side)
   );

   // cross product c = N x d
   logic                    b_valid_ff;
   logic [2:0][CROSS_W-1:0] b_c_ff, b_c_in;
   logic [IDX_W-1:0]        b_r_ff, b_r_in;
   logic [2:0][VEC_W-1:0]   b_nrm_ff;

   always_comb begin
      logic signed [2*VEC_W-1:0] p1, p2;
      logic signed [2*VEC_W:0]   df, sh;
      int i1, i2;
      for (int k = 0; k < 3; k++) begin
         i1 = (k == 2) ? 0 : k + 1;
         i2 = (k == 0) ? 2 : k - 1;
         p1 = $signed(d1_side.nrm[i1]) * $signed(d1_side.dir[i2]);
         p2 = $signed(d1_side.nrm[i2]) * $signed(d1_side.dir[i1]);
         df = $signed({p1[2*VEC_W-1], p1}) - $signed({p2[2*VEC_W-1], p2});
         sh = df >>> FRAC_BITS;
         b_c_in[k] = sh[CROSS_W-1:0];
      end
      b_r_in = d1_side.sat ? '1 : d1_quo;
   end

   // c squares, u = -(N x c), r squared
   logic                   c_valid_ff;
   logic [2:0][CSQ_W-1:0]  c_sq_ff, c_sq_in;
   logic [2:0][UVEC_W-1:0] c_u_ff, c_u_in;
   logic [R2_W-1:0]        c_r2_ff, c_r2_in;
   logic [IDX_W-1:0]       c_r_ff;
   logic [2:0][VEC_W-1:0]  c_nrm_ff;

   always_comb begin
      logic signed [2*CROSS_W-1:0]      sq;
      logic signed [VEC_W+CROSS_W-1:0]  p1, p2;
      logic signed [VEC_W+CROSS_W:0]    df, sh;
      logic [2*IDX_W-1:0]               rr;
      int i1, i2;
      for (int k = 0; k < 3; k++) begin
         i1 = (k == 2) ? 0 : k + 1;
         i2 = (k == 0) ? 2 : k - 1;
         sq = $signed(b_c_ff[k]) * $signed(b_c_ff[k]);
         c_sq_in[k] = sq[CSQ_W-1:0];
         p1 = $signed(b_nrm_ff[i2]) * $signed(b_c_ff[i1]);
         p2 = $signed(b_nrm_ff[i1]) * $signed(b_c_ff[i2]);
         df = $signed({p1[VEC_W+CROSS_W-1], p1}) - $signed({p2[VEC_W+CROSS_W-1], p2});
         sh = df >>> FRAC_BITS;
         c_u_in[k] = sh[UVEC_W-1:0];
      end
      rr      = b_r_ff * b_r_ff;
      c_r2_in = rr[2*IDX_W-1:FRAC_BITS];
   end

   // cc = (c.c) / 2^F
   logic                   dd_valid_ff;
   logic [CC_W-1:0]        dd_cc_ff, dd_cc_in;
   logic [R2_W-1:0]        dd_r2_ff;
   logic [IDX_W-1:0]       dd_r_ff;
   logic [2:0][UVEC_W-1:0] dd_u_ff;
   logic [2:0][VEC_W-1:0]  dd_nrm_ff;

   always_comb begin
      logic [CSQ_W:0] sum;
      sum = (CSQ_W+1)'(c_sq_ff[0]) + (CSQ_W+1)'(c_sq_ff[1]) + (CSQ_W+1)'(c_sq_ff[2]);
      dd_cc_in = sum[CSQ_W:FRAC_BITS];
   end

   // r2 * cc
   logic                   e_valid_ff;
   logic [PROD_W-1:0]      e_prod_ff;
   logic [IDX_W-1:0]       e_r_ff;
   logic [2:0][UVEC_W-1:0] e_u_ff;
   logic [2:0][VEC_W-1:0]  e_nrm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff  <= 1'b0;
         c_valid_ff  <= 1'b0;
         dd_valid_ff <= 1'b0;
         e_valid_ff  <= 1'b0;
      end else if (adv) begin
         b_valid_ff  <= d1_valid;
         c_valid_ff  <= b_valid_ff;
         dd_valid_ff <= c_valid_ff;
         e_valid_ff  <= dd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_c_ff    <= b_c_in;
         b_r_ff    <= b_r_in;
         b_nrm_ff  <= d1_side.nrm;
         c_sq_ff   <= c_sq_in;
         c_u_ff    <= c_u_in;
         c_r2_ff   <= c_r2_in;
         c_r_ff    <= b_r_ff;
         c_nrm_ff  <= b_nrm_ff;
         dd_cc_ff  <= dd_cc_in;
         dd_r2_ff  <= c_r2_ff;
         dd_r_ff   <= c_r_ff;
         dd_u_ff   <= c_u_ff;
         dd_nrm_ff <= c_nrm_ff;
         e_prod_ff <= PROD_W'(dd_r2_ff * dd_cc_ff);
         e_r_ff    <= dd_r_ff;
         e_u_ff    <= dd_u_ff;
         e_nrm_ff  <= dd_nrm_ff;
      end
   end

   // radicand and its root
   root_side_type          s1_side_in, s1_side;
   logic [2*ROOT1_W-1:0]   s1_rad;
   logic                   s1_valid;
   logic [ROOT1_W-1:0]     s1_root;

   always_comb begin
      s1_side_in.tir   = e_prod_ff > ONE_SQ;
      s1_side_in.ratio = e_r_ff;
      s1_side_in.uvec  = e_u_ff;
      s1_side_in.nrm   = e_nrm_ff;
      if (s1_side_in.tir) begin
         s1_rad = '0;
      end else begin
         s1_rad = (2*ROOT1_W)'(ONE_SQ - e_prod_ff);
      end
   end

   vru_sqrt #(.RW(ROOT1_W), .SW($bits(root_side_type))) u_rad_sqrt (
      .clock   (clock),
      .reset   (reset),
      .enable  (adv),
      .valid_i (e_valid_ff),
      .rad     (s1_rad),
      .side_i  (s1_side_in),
      .valid_o (s1_valid),
      .root    (s1_root),
      .side_o  (s1_side)
   );

   // v = r*u - N*s
   logic                 g_valid_ff;
   logic                 g_tir_ff;
   logic [2:0][RU_W-1:0] g_ru_ff, g_ru_in;
   logic [2:0][NS_W-1:0] g_ns_ff, g_ns_in;

   always_comb begin
      logic signed [RU_W-1:0] ru;
      logic signed [NS_W-1:0] ns;
      for (int k = 0; k < 3; k++) begin
         ru = $signed({1'b0, s1_side.ratio}) * $signed(s1_side.uvec[k]);
         ns = $signed(s1_side.nrm[k]) * $signed({1'b0, s1_root});
         g_ru_in[k] = ru;
         g_ns_in[k] = ns;
      end
   end

   logic                  h_valid_ff;
   logic                  h_tir_ff;
   logic [2:0][MAG_W-1:0] h_mag_ff, h_mag_in;
   logic [2:0]            h_neg_ff, h_neg_in;

   always_comb begin
      logic signed [RU_W:0] v;
      for (int k = 0; k < 3; k++) begin
         v = $signed({g_ru_ff[k][RU_W-1], g_ru_ff[k]})
             - $signed((RU_W+1)'($signed(g_ns_ff[k])));
         h_neg_in[k] = v[RU_W];
         if (v[RU_W]) begin
            h_mag_in[k] = MAG_W'(-v);
         end else begin
            h_mag_in[k] = MAG_W'(v);
         end
      end
   end

   // largest magnitude
   logic                  i_valid_ff;
   logic                  i_tir_ff;
   logic                  i_deg_ff;
   logic [MAG_W-1:0]      i_max_ff, i_max_in;
   logic [2:0][MAG_W-1:0] i_mag_ff;
   logic [2:0]            i_neg_ff;

   always_comb begin
      i_max_in = h_mag_ff[0];
      if (h_mag_ff[1] > i_max_in) begin
         i_max_in = h_mag_ff[1];
      end
      if (h_mag_ff[2] > i_max_in) begin
         i_max_in = h_mag_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
         i_valid_ff <= 1'b0;
      end else if (adv) begin
         g_valid_ff <= s1_valid;
         h_valid_ff <= g_valid_ff;
         i_valid_ff <= h_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_tir_ff <= s1_side.tir;
         g_ru_ff  <= g_ru_in;
         g_ns_ff  <= g_ns_in;
         h_tir_ff <= g_tir_ff;
         h_mag_ff <= h_mag_in;
         h_neg_ff <= h_neg_in;
         i_tir_ff <= h_tir_ff;
         i_deg_ff <= i_max_in == '0;
         i_max_ff <= i_max_in;
         i_mag_ff <= h_mag_ff;
         i_neg_ff <= h_neg_ff;
      end
   end

   // normalizing shifter, one shift step per stage
   logic [NORM_STEPS-1:0]  nz_valid_ff;
   logic [NORM_W-1:0]      nz_m_ff [NORM_STEPS];
   logic [NORM_W-1:0]      nz_m_in [NORM_STEPS];
   logic [2:0][NORM_W-1:0] nz_a_ff [NORM_STEPS];
   logic [2:0][NORM_W-1:0] nz_a_in [NORM_STEPS];
   lane_side_type          nz_fl_ff [NORM_STEPS];
   logic [2:0]             nz_neg_ff [NORM_STEPS];

   always_comb begin
      logic [NORM_W-1:0]      mp;
      logic [2:0][NORM_W-1:0] ap;
      int sa;
      for (int j = 0; j < NORM_STEPS; j++) begin
         sa = (NORM_W / 2) >> j;
         if (j == 0) begin
            mp = NORM_W'(i_max_ff);
            for (int k = 0; k < 3; k++) begin
               ap[k] = NORM_W'(i_mag_ff[k]);
            end
         end else begin
            mp = nz_m_ff[j-1];
            ap = nz_a_ff[j-1];
         end
         if ((mp >> (NORM_W - sa)) == '0) begin
            nz_m_in[j] = mp << sa;
            for (int k = 0; k < 3; k++) begin
               nz_a_in[j][k] = ap[k] << sa;
            end
         end else begin
            nz_m_in[j] = mp;
            nz_a_in[j] = ap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nz_valid_ff <= '0;
      end else if (adv) begin
         nz_valid_ff <= NORM_STEPS'({nz_valid_ff, i_valid_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < NORM_STEPS; j++) begin
            nz_m_ff[j] <= nz_m_in[j];
            nz_a_ff[j] <= nz_a_in[j];
            if (j == 0) begin
               nz_fl_ff[j]  <= '{tir: i_tir_ff, deg: i_deg_ff, neg: 1'b0};
               nz_neg_ff[j] <= i_neg_ff;
            end else begin
               nz_fl_ff[j]  <= nz_fl_ff[j-1];
               nz_neg_ff[j] <= nz_neg_ff[j-1];
            end
         end
      end
   end

   // squares and sum of squares
   logic                     j_valid_ff;
   lane_side_type            j_fl_ff;
   logic [2:0]               j_neg_ff;
   logic [2:0][NMAN_W-1:0]   j_a_ff, j_a_in;
   logic [2:0][2*NMAN_W-1:0] j_sq_ff;
   logic                     k_valid_ff;
   lane_side_type            k_fl_ff;
   logic [2:0]               k_neg_ff;
   logic [2:0][NMAN_W-1:0]   k_a_ff;
   logic [SUMSQ_W-1:0]       k_sum_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         j_a_in[k] = nz_a_ff[NORM_STEPS-1][k][NORM_W-1 -: NMAN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_valid_ff <= 1'b0;
         k_valid_ff <= 1'b0;
      end else if (adv) begin
         j_valid_ff <= nz_valid_ff[NORM_STEPS-1];
         k_valid_ff <= j_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         j_fl_ff  <= nz_fl_ff[NORM_STEPS-1];
         j_neg_ff <= nz_neg_ff[NORM_STEPS-1];
         j_a_ff   <= j_a_in;
         for (int k = 0; k < 3; k++) begin
            j_sq_ff[k] <= j_a_in[k] * j_a_in[k];
         end
         k_fl_ff  <= j_fl_ff;
         k_neg_ff <= j_neg_ff;
         k_a_ff   <= j_a_ff;
         k_sum_ff <= SUMSQ_W'(j_sq_ff[0]) + SUMSQ_W'(j_sq_ff[1]) + SUMSQ_W'(j_sq_ff[2]);
      end
   end

   // vector length
   len_side_type         s2_side_in, s2_side;
   logic                 s2_valid;
   logic [ROOT2_W-1:0]   s2_len;

   always_comb begin
      s2_side_in.tir = k_fl_ff.tir;
      s2_side_in.deg = k_fl_ff.deg;
      s2_side_in.neg = k_neg_ff;
      s2_side_in.mag = k_a_ff;
   end

   vru_sqrt #(.RW(ROOT2_W), .SW($bits(len_side_type))) u_len_sqrt (
      .clock   (clock),
      .reset   (reset),
      .enable  (adv),
      .valid_i (k_valid_ff),
      .rad     (k_sum_ff),
      .side_i  (s2_side_in),
      .valid_o (s2_valid),
      .root    (s2_len),
      .side_o  (s2_side)
   );

   // rounded dividend
   logic                  l_valid_ff;
   logic [2:0][NUM_W-1:0] l_num_ff;
   logic [ROOT2_W-1:0]    l_len_ff;
   lane_side_type         l_side_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         l_valid_ff <= 1'b0;
      end else if (adv) begin
         l_valid_ff <= s2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l_len_ff <= s2_len;
         for (int k = 0; k < 3; k++) begin
            l_num_ff[k]  <= NUM_W'({s2_side.mag[k], {FRAC_BITS{1'b0}}})
                            + NUM_W'(s2_len[ROOT2_W-1:1]);
            l_side_ff[k] <= '{tir: s2_side.tir, deg: s2_side.deg, neg: s2_side.neg[k]};
         end
      end
   end

   // per-component quotient
   logic [2:0]       q_valid;
   logic [QUO_W-1:0] q_quo  [3];
   lane_side_type    q_side [3];

   for (genvar k = 0; k < 3; k++) begin : g_lane
      vru_div #(.DW(ROOT2_W), .QW(QUO_W), .SW($bits(lane_side_type))) u_out_div (
         .clock   (clock),
         .reset   (reset),
         .enable  (adv),
         .valid_i (l_valid_ff),
         .num_hi  (ROOT2_W'(l_num_ff[k][NUM_W-1:QUO_W])),
         .num_lo  (l_num_ff[k][QUO_W-1:0]),
         .den     (l_len_ff),
         .side_i  (l_side_ff[k]),
         .valid_o (q_valid[k]),
         .quo     (q_quo[k]),
         .side_o  (q_side[k])
      );
   end

   // output register
   logic                   out_valid_ff;
   logic [2:0][COMP_W-1:0] out_vec_ff, out_vec_in;
   logic                   out_tir_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (q_side[k].tir || q_side[k].deg) begin
            out_vec_in[k] = '0;
         end else if (q_side[k].neg) begin
            if ({1'b0, q_quo[k]} > 17'd32768) begin
               out_vec_in[k] = 16'h8000;
            end else begin
               out_vec_in[k] = -q_quo[k];
            end
         end else if (q_quo[k] > 16'd32767) begin
            out_vec_in[k] = 16'h7FFF;
         end else begin
            out_vec_in[k] = q_quo[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= q_valid[0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_vec_ff <= out_vec_in;
         out_tir_ff <= q_side[0].tir;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_vec_ff;
   assign rsp_tuser[0] = out_tir_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("reflection result with nonzero direction");

   assert property (@(posedge clock) disable iff (reset)
      q_valid[0] == q_valid[1] && q_valid[1] == q_valid[2])
      else $error("output divider lanes out of step");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         $signed(rsp_tdata[15:0]) >= -16384 && $signed(rsp_tdata[15:0]) <= 16384 &&
         $signed(rsp_tdata[31:16]) >= -16384 && $signed(rsp_tdata[31:16]) <= 16384 &&
         $signed(rsp_tdata[47:32]) >= -16384 && $signed(rsp_tdata[47:32]) <= 16384)
      else $error("normalized component exceeds unit range");
`endif

endmodule

@@ tb/sv/tb_vector_refraction_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_vector_refraction_unit
// Self-checking bench for the vector refraction pipeline.
// ---------------------------------------------------------------------------
// Rays are driven on the request stream, starting with a short table of rays
// (extremes, total reflection, zero index, saturated ratio, zero normal) and
// followed by random rays, mostly near-unit vectors. Each transaction's result
// is predicted in fixed point and compared in order with the response stream.
// Both sides idle in random bursts, except in the last part of the run.
// ---------------------------------------------------------------------------
module tb_vector_refraction_unit
   import vru_pkg::*;
();

   typedef struct {
      logic [15:0] dir [3];
      logic [15:0] nrm [3];
      logic [15:0] n_in;
      logic [15:0] n_out;
      logic        flip;
   } ray_type;

   typedef struct {
      logic [15:0] comp [3];
      logic        tir;
   } refr_type;

   typedef struct {
      ray_type  ray;
      bit       known;
      refr_type res;
   } row_type;

   localparam int N_RANDOM    = 750;
   localparam int LATENCY     = 96;
   localparam int CYCLE_LIMIT = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;

   refr_type expected_refr [$];
   row_type  rows [$];
   int    errors = 0;
   int    cycles = 0;
   bit    quiet = 1'b0;
   bit    drain = 1'b0;

   always #1 clock = ~clock;

   vector_refraction_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   function automatic longint fl_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic refr_type refract(ray_type ray);
      refr_type o;
      longint d [3], n [3], c [3], u [3], v [3];
      longint unsigned a [3], m, sumsq, len, n1, n2, r, r2, cc, one2, rad, s, q;
      o.comp = '{16'd0, 16'd0, 16'd0};
      o.tir = 1'b0;
      for (int k = 0; k < 3; k++) begin
         d[k] = longint'($signed(ray.dir[k]));
         n[k] = longint'($signed(ray.nrm[k]));
         if (ray.flip) n[k] = -n[k];
      end
      n1 = ray.n_in;
      n2 = (ray.n_out == 0) ? 1 : ray.n_out;
      r = (n1 << FRAC_BITS) / n2;
      if (r > (64'd4 << FRAC_BITS) - 1) r = (64'd4 << FRAC_BITS) - 1;
      r2 = (r * r) >> FRAC_BITS;
      c[0] = fl_shift(n[1] * d[2] - n[2] * d[1], FRAC_BITS);
      c[1] = fl_shift(n[2] * d[0] - n[0] * d[2], FRAC_BITS);
      c[2] = fl_shift(n[0] * d[1] - n[1] * d[0], FRAC_BITS);
      cc = 0;
      for (int k = 0; k < 3; k++) cc += longint'(c[k] * c[k]);
      cc >>= FRAC_BITS;
      one2 = 64'd1 << (2 * FRAC_BITS);
      if (cc != 0 && r2 > one2 / cc) begin
         o.tir = 1'b1;
         return o;
      end
      rad = one2 - r2 * cc;
      s = int_sqrt(rad);
      u[0] = fl_shift(-(n[1] * c[2] - n[2] * c[1]), FRAC_BITS);
      u[1] = fl_shift(-(n[2] * c[0] - n[0] * c[2]), FRAC_BITS);
      u[2] = fl_shift(-(n[0] * c[1] - n[1] * c[0]), FRAC_BITS);
      m = 0;
      for (int k = 0; k < 3; k++) begin
         v[k] = longint'(r) * u[k] - n[k] * longint'(s);
         a[k] = (v[k] < 0) ? longint'(-v[k]) : longint'(v[k]);
         if (a[k] > m) m = a[k];
      end
      if (m == 0) return o;
      while (m >= (64'd1 << 30)) begin
         m >>= 1;
         for (int k = 0; k < 3; k++) a[k] >>= 1;
      end
      while (m < (64'd1 << 29)) begin
         m <<= 1;
         for (int k = 0; k < 3; k++) a[k] <<= 1;
      end
      sumsq = 0;
      for (int k = 0; k < 3; k++) sumsq += a[k] * a[k];
      len = int_sqrt(sumsq);
      for (int k = 0; k < 3; k++) begin
         q = ((a[k] << FRAC_BITS) + (len >> 1)) / len;
         if (v[k] < 0) begin
            if (q > 32768) q = 32768;
            o.comp[k] = 16'(-longint'(q));
         end else begin
            if (q > 32767) q = 32767;
            o.comp[k] = 16'(q);
         end
      end
      return o;
   endfunction

   function automatic ray_type make_ray(int dx, int dy, int dz, int nx, int ny, int nz,
                                        int ni, int no, bit fl);
      ray_type ray;
      ray.dir = '{16'(dx), 16'(dy), 16'(dz)};
      ray.nrm = '{16'(nx), 16'(ny), 16'(nz)};
      ray.n_in = 16'(ni);
      ray.n_out = 16'(no);
      ray.flip = fl;
      return ray;
   endfunction

   function automatic int rand_comp();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return int'($signed(16'($urandom)));
      if (sel == 1) return ($urandom_range(0, 1) ? 16384 : -16384);
      return $urandom_range(0, 32768) - 16384;
   endfunction

   function automatic ray_type rand_ray();
      ray_type ray;
      real v [3], w [3], l;
      int noise;
      noise = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < 3; k++) begin
         v[k] = real'(rand_comp());
         w[k] = real'(rand_comp());
      end
      if (!noise) begin
         l = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]) + 1.0;
         for (int k = 0; k < 3; k++) v[k] = v[k] * 16384.0 / l;
         l = $sqrt(w[0] * w[0] + w[1] * w[1] + w[2] * w[2]) + 1.0;
         for (int k = 0; k < 3; k++) w[k] = w[k] * 16384.0 / l;
      end
      for (int k = 0; k < 3; k++) begin
         ray.dir[k] = 16'($rtoi(v[k]));
         ray.nrm[k] = 16'($rtoi(w[k]));
      end
      if (noise) begin
         ray.n_in = 16'($urandom);
         ray.n_out = 16'($urandom);
      end else begin
         ray.n_in = 16'($urandom_range(16384, 40000));
         ray.n_out = 16'($urandom_range(16384, 40000));
      end
      ray.flip = $urandom_range(0, 1);
      return ray;
   endfunction

   task automatic add_row(ray_type ray, bit known, refr_type res);
      row_type row;
      row.ray = ray;
      row.known = known;
      row.res = res;
      rows.insert(rows.size(), row);
   endtask

   task automatic send_ray(ray_type ray, refr_type res);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {ray.n_out, ray.n_in, ray.nrm[2], ray.nrm[1], ray.nrm[0],
                    ray.dir[2], ray.dir[1], ray.dir[0]};
      req_tuser <= ray.flip;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_refr.insert(expected_refr.size(), res);
      @(negedge clock);
   endtask

   initial begin : stimulus
      refr_type zero, tir, unit_z, neg_z;
      zero.comp = '{16'd0, 16'd0, 16'd0};
      zero.tir = 1'b0;
      tir = zero;
      tir.tir = 1'b1;
      unit_z = zero;
      unit_z.comp[2] = 16'd16384;
      neg_z = zero;
      neg_z.comp[2] = 16'hC000;
      // head-on ray through -z normal, and flipped, then reversed against +z normal
      add_row(make_ray(0, 0, 16384, 0, 0, -16384, 16384, 16384, 0), 1, unit_z);
      add_row(make_ray(0, 0, 16384, 0, 0, 16384, 16384, 16384, 1), 1, unit_z);
      add_row(make_ray(0, 0, -16384, 0, 0, 16384, 16384, 16384, 0), 1, neg_z);
      // grazing ray from dense medium
      add_row(make_ray(16384, 0, 0, 0, 0, -16384, 65535, 16384, 0), 1, tir);
      add_row(make_ray(0, -16384, 0, 0, 0, 16384, 24576, 16384, 1), 1, tir);
      // zero normal
      add_row(make_ray(11585, 0, 11585, 0, 0, 0, 16384, 16384, 0), 1, zero);
      add_row(make_ray(0, 0, 0, 0, 0, 0, 65535, 0, 1), 1, zero);
      // zero transmitted index, saturated ratio and further mixed rays
      add_row(make_ray(0, 0, 16384, 0, 0, -16384, 40000, 0, 0), 0, zero);
      add_row(make_ray(3000, 0, 16000, 0, 0, -16384, 65535, 16384, 0), 0, zero);
      add_row(make_ray(11585, 0, 11585, 0, 0, -16384, 16384, 24576, 0), 0, zero);
      add_row(make_ray(11585, 0, 11585, 0, 0, -16384, 24576, 16384, 0), 0, zero);
      add_row(make_ray(-32768, -32768, -32768, 32767, 32767, 32767, 65535, 65535, 1),
              0, zero);
      add_row(make_ray(32767, -32768, 32767, -32768, 32767, -32768, 0, 65535, 0), 0, zero);
      add_row(make_ray(-16384, 16384, -16384, 16384, -16384, 16384, 16384, 65535, 1),
              0, zero);
      add_row(make_ray(9459, 9459, 9459, -9459, -9459, -9459, 20000, 30000, 0), 0, zero);
      add_row(make_ray(0, 16384, 0, 0, -16384, 0, 16384, 16384, 1), 0, zero);
      add_row(make_ray(16384, 0, 0, 0, 0, -16384, 16384, 16384, 0), 0, zero);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (rows[i]) begin
         if (rows[i].known) send_ray(rows[i].ray, rows[i].res);
         else send_ray(rows[i].ray, refract(rows[i].ray));
      end
      req_tvalid <= 1'b0;
      // hold off until the pipeline has drained
      while (expected_refr.size() != 0) @(negedge clock);
      for (int i = 0; i < N_RANDOM; i++) begin
         ray_type ray;
         if (i == N_RANDOM - 100) quiet = 1'b1;
         ray = rand_ray();
         send_ray(ray, refract(ray));
      end
      req_tvalid <= 1'b0;
      drain = 1'b1;
   end

   initial begin : sink
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_refr.size() == 0) begin
            $display("%t: unexpected transaction %h/%b", $realtime, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            refr_type e;
            e = expected_refr.pop_front();
            if ({e.comp[2], e.comp[1], e.comp[0]} !== rsp_tdata || e.tir !== rsp_tuser[0]) begin
               $display("%t: expected %h/%b actual %h/%b", $realtime,
                        {e.comp[2], e.comp[1], e.comp[0]}, e.tir, rsp_tdata, rsp_tuser);
               errors++;
            end
         end
      end
   end

   initial begin : finish_ctl
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("vector_refraction_unit: mismatch");
            $finish;
         end
         if (drain && expected_refr.size() == 0) begin
            repeat (LATENCY) @(posedge clock);
            if (errors == 0 && expected_refr.size() == 0) begin
               $display("vector_refraction_unit: match");
            end else begin
               $display("vector_refraction_unit: mismatch");
            end
            $finish;
         end
      end
   end

endmodule
